@@ rtl/core/dls_pkg.sv @@
// Shared types, codes and helpers for the door lock sequencer.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package dls_pkg;

    localparam int CMD_W    = 3;
    localparam int ERR_W    = 2;
    localparam int SIG_W    = 4;
    localparam int MS_W     = 16;
    localparam int STATE_W  = 3;
    localparam int DOOR_W   = 2;
    localparam int CFG_IDX_W = 3;

    // Commands carried by an input item.
    localparam logic [CMD_W-1:0] CMD_OPEN_SAFE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_OPEN_UNSAFE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLOSE       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TIMEOUT     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SENSOR      = 3'd4;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_BUSY  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FAULT = 2'd2;

    // Door states: open*2 + locked.
    localparam logic [DOOR_W-1:0] DS_CLOSED = 2'd0;
    localparam logic [DOOR_W-1:0] DS_LOCKED = 2'd1;
    localparam logic [DOOR_W-1:0] DS_OPEN   = 2'd2;
    localparam logic [DOOR_W-1:0] DS_FAULT  = 2'd3;

    // Signal codes.
    localparam logic [SIG_W-1:0] SG_NONE          = 4'd0;
    localparam logic [SIG_W-1:0] SG_OPENING       = 4'd1;
    localparam logic [SIG_W-1:0] SG_UNLOCKED      = 4'd2;
    localparam logic [SIG_W-1:0] SG_OPENED        = 4'd3;
    localparam logic [SIG_W-1:0] SG_NO_ENTRY      = 4'd4;
    localparam logic [SIG_W-1:0] SG_ERROR_OPENING = 4'd5;
    localparam logic [SIG_W-1:0] SG_WAIT_CLOSED   = 4'd6;
    localparam logic [SIG_W-1:0] SG_LOCKING       = 4'd7;
    localparam logic [SIG_W-1:0] SG_LOCKED        = 4'd8;
    localparam logic [SIG_W-1:0] SG_CLOSE_TIMEOUT = 4'd9;
    localparam logic [SIG_W-1:0] SG_MAN_LOCKED    = 4'd10;
    localparam logic [SIG_W-1:0] SG_MAN_UNLOCKED  = 4'd11;
    localparam logic [SIG_W-1:0] SG_ERROR_LOCKING = 4'd12;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BUTTON_PRESS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENGAGE_BOLT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DISENGAGE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_USER_OPEN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_USER_CLOSE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_DOOR    = 3'd5;

    // Register reset values.
    localparam logic [MS_W-1:0]   RST_BUTTON_PRESS = 16'd100;
    localparam logic [MS_W-1:0]   RST_ENGAGE_BOLT  = 16'd20000;
    localparam logic [MS_W-1:0]   RST_DISENGAGE    = 16'd20000;
    localparam logic [MS_W-1:0]   RST_USER_OPEN    = 16'd60000;
    localparam logic [MS_W-1:0]   RST_USER_CLOSE   = 16'd30000;
    localparam logic [DOOR_W-1:0] RST_INIT_DOOR    = DS_LOCKED;

    // Controller states, one-hot.
    typedef enum logic [6:0] {
        ST_IDLE          = 7'b0000001,
        ST_INIT_OPEN     = 7'b0000010,
        ST_WAIT_UNLOCKED = 7'b0000100,
        ST_WAIT_OPEN     = 7'b0001000,
        ST_WAIT_CLOSED   = 7'b0010000,
        ST_INIT_LOCK     = 7'b0100000,
        ST_WAIT_LOCKED   = 7'b1000000
    } t_ctrl_state;

    // Numeric state code as seen on the result item; idle is zero.
    function automatic logic [STATE_W-1:0] state_code(input t_ctrl_state s);
        logic [STATE_W-1:0] c;
        case (s)
            ST_IDLE:          c = 3'd0;
            ST_INIT_OPEN:     c = 3'd1;
            ST_WAIT_UNLOCKED: c = 3'd2;
            ST_WAIT_OPEN:     c = 3'd3;
            ST_WAIT_CLOSED:   c = 3'd4;
            ST_INIT_LOCK:     c = 3'd5;
            ST_WAIT_LOCKED:   c = 3'd6;
            default:          c = 3'd0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/door_lock_sequencer_unit.sv @@
// Door lock sequencer: the whole block in one module.
// Depends on dls_pkg for codes, the state type and the state encoding.
//
// Usage: commands arrive on the input channel (i_in_valid, o_in_stall) and each
// item yields exactly one result item on the output channel (o_out_valid,
// i_out_stall). An item is accepted into an input register; the transition
// logic then runs on it and the result, together with the updated
// controller state, lands in the result register once that register can
// advance. One item per cycle is sustained while the receiver does not stall;
// the controller and door state feed back through the combinational
// transition logic.
// When the receiver stalls, the result register holds; the input register
// still takes one more item, after which o_in_stall rises until the result
// is taken.
// Configuration is a separate write channel that is always ready; writing the
// initial door state index loads the stored door state; no register keeps it.
// Synchronous active-low reset empties both registers, puts the controller in
// idle, releases both buttons, clears the unsafe flag, restores the register
// defaults and loads the door state with the default initial door state.
`timescale 1ns / 1ps
`default_nettype none

module door_lock_sequencer_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [dls_pkg::CMD_W-1:0]     i_command,
    input  wire logic                          i_lock_sensed,
    input  wire logic                          i_open_sensed,
    // Result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [dls_pkg::ERR_W-1:0]          o_error_code,
    output logic [dls_pkg::SIG_W-1:0]          o_signal_code,
    output logic                               o_trigger_open,
    output logic                               o_trigger_close,
    output logic                               o_timer_load,
    output logic [dls_pkg::MS_W-1:0]           o_timeout_ms,
    output logic [dls_pkg::STATE_W-1:0]        o_controller_state,
    output logic [dls_pkg::DOOR_W-1:0]         o_door_now,
    // Configuration write channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [dls_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [dls_pkg::MS_W-1:0]      i_cfg_data
);
    import dls_pkg::*;

    // Configuration registers
    logic [MS_W-1:0]   r_button_press_ms;
    logic [MS_W-1:0]   r_engage_bolt_ms;
    logic [MS_W-1:0]   r_disengage_bolt_ms;
    logic [MS_W-1:0]   r_user_open_ms;
    logic [MS_W-1:0]   r_user_close_ms;

    // Controller state
    t_ctrl_state       r_ctrl;
    logic [DOOR_W-1:0] r_door;
    logic              r_unsafe;
    logic              r_open_btn;
    logic              r_close_btn;

    // Input register
    logic              r_s1_valid;
    logic [CMD_W-1:0]  r_s1_cmd;
    logic              r_s1_lock;
    logic              r_s1_open;

    // Result register
    logic              r_out_valid;
    logic [ERR_W-1:0]  r_err;
    logic [SIG_W-1:0]  r_sig;
    logic              r_trig_open;
    logic              r_trig_close;
    logic              r_load;
    logic [MS_W-1:0]   r_tmo;
    logic [STATE_W-1:0] r_state_code;
    logic [DOOR_W-1:0] r_door_now;

    // Next values from the transition logic
    t_ctrl_state       n_ctrl;
    logic [DOOR_W-1:0] n_door;
    logic              n_unsafe;
    logic              n_open_btn;
    logic              n_close_btn;
    logic [ERR_W-1:0]  n_err;
    logic [SIG_W-1:0]  n_sig;
    logic              n_load;
    logic [MS_W-1:0]   n_tmo;

    logic              advance;
    logic              fire;
    logic              cfg_we;
    logic              do_enter;
    t_ctrl_state       enter_st;
    logic [DOOR_W-1:0] sensed_door;

    assign advance     = !r_out_valid || !i_out_stall;
    assign fire        = r_s1_valid && advance;
    assign o_in_stall  = r_s1_valid && !advance;
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign sensed_door = {r_s1_open, r_s1_lock};

    always_comb begin
        n_ctrl      = r_ctrl;
        n_door      = r_door;
        n_unsafe    = r_unsafe;
        n_open_btn  = r_open_btn;
        n_close_btn = r_close_btn;
        n_err       = ERR_OK;
        n_sig       = SG_NONE;
        n_load      = 1'b0;
        n_tmo       = '0;
        do_enter    = 1'b0;
        enter_st    = ST_IDLE;

        case (r_s1_cmd)
            CMD_OPEN_SAFE, CMD_OPEN_UNSAFE: begin
                if (r_ctrl != ST_IDLE) begin
                    n_err = ERR_BUSY;
                end else begin
                    n_unsafe = (r_s1_cmd == CMD_OPEN_UNSAFE);
                    if (r_door == DS_LOCKED) begin
                        do_enter = 1'b1;
                        enter_st = ST_INIT_OPEN;
                    end else if (r_door == DS_FAULT) begin
                        n_err = ERR_FAULT;
                    end
                end
            end
            CMD_CLOSE: begin
                if (r_ctrl != ST_IDLE) begin
                    n_err = ERR_BUSY;
                end else if (r_door == DS_OPEN) begin
                    do_enter = 1'b1;
                    enter_st = ST_WAIT_CLOSED;
                end else if (r_door == DS_CLOSED) begin
                    do_enter = 1'b1;
                    enter_st = ST_INIT_LOCK;
                end else if (r_door == DS_FAULT) begin
                    n_err = ERR_FAULT;
                end
            end
            CMD_TIMEOUT: begin
                case (r_ctrl)
                    ST_INIT_OPEN: begin
                        do_enter = 1'b1;
                        enter_st = ST_WAIT_UNLOCKED;
                    end
                    ST_WAIT_UNLOCKED: begin
                        n_sig    = SG_ERROR_OPENING;
                        do_enter = 1'b1;
                        enter_st = ST_IDLE;
                    end
                    ST_WAIT_OPEN: begin
                        n_sig    = SG_NO_ENTRY;
                        do_enter = 1'b1;
                        enter_st = ST_INIT_LOCK;
                    end
                    ST_WAIT_CLOSED: begin
                        n_sig    = SG_CLOSE_TIMEOUT;
                        do_enter = 1'b1;
                        enter_st = ST_IDLE;
                    end
                    ST_INIT_LOCK: begin
                        do_enter = 1'b1;
                        enter_st = ST_WAIT_LOCKED;
                    end
                    ST_WAIT_LOCKED: begin
                        n_sig    = SG_ERROR_LOCKING;
                        do_enter = 1'b1;
                        enter_st = ST_IDLE;
                    end
                    default: begin
                    end
                endcase
            end
            CMD_SENSOR: begin
                // A sensor item that repeats the stored door state is ignored.
                if (sensed_door != r_door) begin
                    n_door = sensed_door;
                    case (r_ctrl)
                        ST_IDLE: begin
                            if (sensed_door == DS_LOCKED) begin
                                n_sig = SG_MAN_LOCKED;
                            end
                            if (r_door == DS_LOCKED) begin
                                n_sig = SG_MAN_UNLOCKED;
                            end
                        end
                        ST_WAIT_UNLOCKED: begin
                            if (sensed_door == DS_CLOSED) begin
                                n_sig    = SG_UNLOCKED;
                                do_enter = 1'b1;
                                enter_st = r_unsafe ? ST_IDLE : ST_WAIT_OPEN;
                            end
                        end
                        ST_WAIT_OPEN: begin
                            if (sensed_door == DS_OPEN) begin
                                n_sig    = SG_OPENED;
                                do_enter = 1'b1;
                                enter_st = ST_IDLE;
                            end
                        end
                        ST_WAIT_CLOSED: begin
                            if (sensed_door == DS_CLOSED) begin
                                n_sig    = SG_LOCKING;
                                do_enter = 1'b1;
                                enter_st = ST_INIT_LOCK;
                            end
                        end
                        ST_WAIT_LOCKED: begin
                            if (sensed_door == DS_LOCKED) begin
                                n_sig    = SG_LOCKED;
                                do_enter = 1'b1;
                                enter_st = ST_IDLE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase

        // Every state entry reloads the timer; the signals set here never
        // collide with one set above, as those paths lead elsewhere.
        if (do_enter) begin
            n_ctrl = enter_st;
            n_load = 1'b1;
            case (enter_st)
                ST_IDLE: begin
                    n_open_btn  = 1'b0;
                    n_close_btn = 1'b0;
                    n_unsafe    = 1'b0;
                    n_tmo       = '0;
                end
                ST_INIT_OPEN: begin
                    n_open_btn = 1'b1;
                    n_tmo      = r_button_press_ms;
                    n_sig      = SG_OPENING;
                end
                ST_WAIT_UNLOCKED: begin
                    n_open_btn = 1'b0;
                    n_tmo      = r_disengage_bolt_ms;
                end
                ST_WAIT_OPEN: begin
                    n_tmo = r_user_open_ms;
                end
                ST_WAIT_CLOSED: begin
                    n_tmo = r_user_close_ms;
                    n_sig = SG_WAIT_CLOSED;
                end
                ST_INIT_LOCK: begin
                    n_close_btn = 1'b1;
                    n_tmo       = r_button_press_ms;
                end
                default: begin
                    n_close_btn = 1'b0;
                    n_tmo       = r_engage_bolt_ms;
                end
            endcase
        end
    end

    // Configuration registers; the initial door state goes straight into
    // the stored door state below.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_button_press_ms   <= RST_BUTTON_PRESS;
            r_engage_bolt_ms    <= RST_ENGAGE_BOLT;
            r_disengage_bolt_ms <= RST_DISENGAGE;
            r_user_open_ms      <= RST_USER_OPEN;
            r_user_close_ms     <= RST_USER_CLOSE;
        end else if (cfg_we) begin
            case (i_cfg_index)
                REG_BUTTON_PRESS: r_button_press_ms   <= i_cfg_data;
                REG_ENGAGE_BOLT:  r_engage_bolt_ms    <= i_cfg_data;
                REG_DISENGAGE:    r_disengage_bolt_ms <= i_cfg_data;
                REG_USER_OPEN:    r_user_open_ms      <= i_cfg_data;
                REG_USER_CLOSE:   r_user_close_ms     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl      <= ST_IDLE;
            r_door      <= RST_INIT_DOOR;
            r_unsafe    <= 1'b0;
            r_open_btn  <= 1'b0;
            r_close_btn <= 1'b0;
        end else begin
            if (fire) begin
                r_ctrl      <= n_ctrl;
                r_unsafe    <= n_unsafe;
                r_open_btn  <= n_open_btn;
                r_close_btn <= n_close_btn;
            end
            if (cfg_we && i_cfg_index == REG_INIT_DOOR) begin
                r_door <= i_cfg_data[DOOR_W-1:0];
            end else if (fire) begin
                r_door <= n_door;
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1_cmd  <= i_command;
            r_s1_lock <= i_lock_sensed;
            r_s1_open <= i_open_sensed;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_err        <= n_err;
            r_sig        <= n_sig;
            r_trig_open  <= n_open_btn;
            r_trig_close <= n_close_btn;
            r_load       <= n_load;
            r_tmo        <= n_tmo;
            r_state_code <= state_code(n_ctrl);
            r_door_now   <= n_door;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_error_code       = r_err;
    assign o_signal_code      = r_sig;
    assign o_trigger_open     = r_trig_open;
    assign o_trigger_close    = r_trig_close;
    assign o_timer_load       = r_load;
    assign o_timeout_ms       = r_tmo;
    assign o_controller_state = r_state_code;
    assign o_door_now         = r_door_now;

endmodule

`default_nettype wire

@@ rtl/core/dls_checker.sv @@
// Port-level checker for the door lock sequencer and its bind to the top level.
// Depends on dls_pkg and on door_lock_sequencer_unit for the port names it watches.
`timescale 1ns / 1ps
`default_nettype none

module dls_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic [dls_pkg::ERR_W-1:0]   o_error_code,
    input wire logic [dls_pkg::SIG_W-1:0]   o_signal_code,
    input wire logic                        o_trigger_open,
    input wire logic                        o_trigger_close,
    input wire logic                        o_timer_load,
    input wire logic [dls_pkg::MS_W-1:0]    o_timeout_ms,
    input wire logic [dls_pkg::STATE_W-1:0] o_controller_state
);
    import dls_pkg::*;

    // A result item that is held back keeps its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_signal_code)
            && $stable(o_timeout_ms) && $stable(o_controller_state))
        else $error("result item changed while stalled");

    // Without a timer reload the timeout field reads zero.
    a_no_load_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_timer_load |-> o_timeout_ms == '0)
        else $error("timeout value without timer load");

    // In idle both motor buttons are released.
    a_idle_buttons: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_controller_state == state_code(ST_IDLE)
            |-> !o_trigger_open && !o_trigger_close)
        else $error("motor button held in idle");

    // A refused command neither signals nor touches the timer.
    a_error_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error_code != ERR_OK |-> !o_timer_load && o_signal_code == SG_NONE)
        else $error("refused command had side effects");

endmodule

bind door_lock_sequencer_unit dls_checker u_dls_checker (.*);

`default_nettype wire

@@ bench/tb_door_lock_sequencer_unit.sv @@
// Self-checking testbench for door_lock_sequencer_unit: a directed table, then
// random command sequences under several register settings, checked against a
// built-in predictor of the lock sequencer. Depends on dls_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_door_lock_sequencer_unit;
    import dls_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int PHASES     = 5;
    localparam int PHASE_ITEMS = 390;
    localparam int MAX_REPORTS = 10;

    // Numeric controller state codes as they appear on the result item.
    localparam logic [STATE_W-1:0] CS_IDLE          = 3'd0;
    localparam logic [STATE_W-1:0] CS_INIT_OPEN     = 3'd1;
    localparam logic [STATE_W-1:0] CS_WAIT_UNLOCKED = 3'd2;
    localparam logic [STATE_W-1:0] CS_WAIT_OPEN     = 3'd3;
    localparam logic [STATE_W-1:0] CS_WAIT_CLOSED   = 3'd4;
    localparam logic [STATE_W-1:0] CS_INIT_LOCK     = 3'd5;
    localparam logic [STATE_W-1:0] CS_WAIT_LOCKED   = 3'd6;

    // Command codes that the block ignores.
    localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_C = 3'd7;

    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PATTERN} t_stall_mode;

    typedef struct packed {
        logic [ERR_W-1:0]   err;
        logic [SIG_W-1:0]   sig;
        logic               trig_open;
        logic               trig_close;
        logic               load;
        logic [MS_W-1:0]    ms;
        logic [STATE_W-1:0] state;
        logic [DOOR_W-1:0]  door;
    } t_door_result;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             lk;
        logic             op;
        logic             typed;
        t_door_result     res;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    logic [CMD_W-1:0] i_command;
    logic i_lock_sensed;
    logic i_open_sensed;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [ERR_W-1:0] o_error_code;
    logic [SIG_W-1:0] o_signal_code;
    logic o_trigger_open;
    logic o_trigger_close;
    logic o_timer_load;
    logic [MS_W-1:0] o_timeout_ms;
    logic [STATE_W-1:0] o_controller_state;
    logic [DOOR_W-1:0] o_door_now;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [MS_W-1:0] i_cfg_data;

    door_lock_sequencer_unit i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_command          (i_command),
        .i_lock_sensed      (i_lock_sensed),
        .i_open_sensed      (i_open_sensed),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_error_code       (o_error_code),
        .o_signal_code      (o_signal_code),
        .o_trigger_open     (o_trigger_open),
        .o_trigger_close    (o_trigger_close),
        .o_timer_load       (o_timer_load),
        .o_timeout_ms       (o_timeout_ms),
        .o_controller_state (o_controller_state),
        .o_door_now         (o_door_now),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Predicted sequencer state and register file.
    logic [STATE_W-1:0] sq_state;
    logic [DOOR_W-1:0]  sq_door;
    logic               sq_unsafe;
    logic               sq_open_btn;
    logic               sq_close_btn;
    logic [MS_W-1:0]    sq_reg [0:5];
    t_door_result       step_res;

    t_door_result pending_results [$];
    int           fails = 0;

    function automatic t_door_result mk_res(
        input logic [ERR_W-1:0] err, input logic [SIG_W-1:0] sig,
        input logic op, input logic cl, input logic load, input logic [MS_W-1:0] ms,
        input logic [STATE_W-1:0] st, input logic [DOOR_W-1:0] door);
        t_door_result r;
        r.err = err;
        r.sig = sig;
        r.trig_open = op;
        r.trig_close = cl;
        r.load = load;
        r.ms = ms;
        r.state = st;
        r.door = door;
        return r;
    endfunction

    // Every state entry reloads the timer; entering idle releases everything.
    function automatic void enter_state(input logic [STATE_W-1:0] s);
        sq_state = s;
        step_res.load = 1'b1;
        case (s)
            CS_IDLE: begin
                sq_open_btn = 1'b0;
                sq_close_btn = 1'b0;
                sq_unsafe = 1'b0;
                step_res.ms = '0;
            end
            CS_INIT_OPEN: begin
                sq_open_btn = 1'b1;
                step_res.ms = sq_reg[REG_BUTTON_PRESS];
                step_res.sig = SG_OPENING;
            end
            CS_WAIT_UNLOCKED: begin
                sq_open_btn = 1'b0;
                step_res.ms = sq_reg[REG_DISENGAGE];
            end
            CS_WAIT_OPEN: step_res.ms = sq_reg[REG_USER_OPEN];
            CS_WAIT_CLOSED: begin
                step_res.ms = sq_reg[REG_USER_CLOSE];
                step_res.sig = SG_WAIT_CLOSED;
            end
            CS_INIT_LOCK: begin
                sq_close_btn = 1'b1;
                step_res.ms = sq_reg[REG_BUTTON_PRESS];
            end
            default: begin
                sq_close_btn = 1'b0;
                step_res.ms = sq_reg[REG_ENGAGE_BOLT];
            end
        endcase
    endfunction

    function automatic t_door_result advance_lock(input logic [CMD_W-1:0] cmd,
                                                  input logic lk, input logic op);
        logic [DOOR_W-1:0] nd;
        logic [DOOR_W-1:0] od;
        step_res = '0;
        nd = {op, lk};
        od = sq_door;
        case (cmd)
            CMD_OPEN_SAFE, CMD_OPEN_UNSAFE: begin
                if (sq_state != CS_IDLE) begin
                    step_res.err = ERR_BUSY;
                end else begin
                    sq_unsafe = (cmd == CMD_OPEN_UNSAFE);
                    if (sq_door == DS_LOCKED)
                        enter_state(CS_INIT_OPEN);
                    else if (sq_door == DS_FAULT)
                        step_res.err = ERR_FAULT;
                end
            end
            CMD_CLOSE: begin
                if (sq_state != CS_IDLE)
                    step_res.err = ERR_BUSY;
                else if (sq_door == DS_OPEN)
                    enter_state(CS_WAIT_CLOSED);
                else if (sq_door == DS_CLOSED)
                    enter_state(CS_INIT_LOCK);
                else if (sq_door == DS_FAULT)
                    step_res.err = ERR_FAULT;
            end
            CMD_TIMEOUT: begin
                case (sq_state)
                    CS_INIT_OPEN: enter_state(CS_WAIT_UNLOCKED);
                    CS_WAIT_UNLOCKED: begin
                        step_res.sig = SG_ERROR_OPENING;
                        enter_state(CS_IDLE);
                    end
                    CS_WAIT_OPEN: begin
                        step_res.sig = SG_NO_ENTRY;
                        enter_state(CS_INIT_LOCK);
                    end
                    CS_WAIT_CLOSED: begin
                        step_res.sig = SG_CLOSE_TIMEOUT;
                        enter_state(CS_IDLE);
                    end
                    CS_INIT_LOCK: enter_state(CS_WAIT_LOCKED);
                    CS_WAIT_LOCKED: begin
                        enter_state(CS_IDLE);
                        step_res.sig = SG_ERROR_LOCKING;
                    end
                    default: ;
                endcase
            end
            CMD_SENSOR: begin
                // A repeated door state is dropped without any effect.
                if (nd != od) begin
                    sq_door = nd;
                    case (sq_state)
                        CS_IDLE: begin
                            if (nd == DS_LOCKED)
                                step_res.sig = SG_MAN_LOCKED;
                            if (od == DS_LOCKED)
                                step_res.sig = SG_MAN_UNLOCKED;
                        end
                        CS_WAIT_UNLOCKED: begin
                            if (nd == DS_CLOSED) begin
                                step_res.sig = SG_UNLOCKED;
                                enter_state(sq_unsafe ? CS_IDLE : CS_WAIT_OPEN);
                            end
                        end
                        CS_WAIT_OPEN: begin
                            if (nd == DS_OPEN) begin
                                step_res.sig = SG_OPENED;
                                enter_state(CS_IDLE);
                            end
                        end
                        CS_WAIT_CLOSED: begin
                            if (nd == DS_CLOSED) begin
                                step_res.sig = SG_LOCKING;
                                enter_state(CS_INIT_LOCK);
                            end
                        end
                        CS_WAIT_LOCKED: begin
                            if (nd == DS_LOCKED) begin
                                step_res.sig = SG_LOCKED;
                                enter_state(CS_IDLE);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        step_res.trig_open = sq_open_btn;
        step_res.trig_close = sq_close_btn;
        step_res.state = sq_state;
        step_res.door = sq_door;
        return step_res;
    endfunction

    // Holds the payload until accepted, then records what the block should return.
    task automatic offer(input logic [CMD_W-1:0] cmd, input logic lk, input logic op,
                         input logic typed, input t_door_result given);
        t_door_result predicted;
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_lock_sensed <= lk;
        i_open_sensed <= op;
        do @(posedge i_clk); while (o_in_stall);
        predicted = advance_lock(cmd, lk, op);
        pending_results.push_back(typed ? given : predicted);
    endtask

    task automatic await_results();
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes every register index in turn, including the two unused ones.
    task automatic program_registers(input logic [7:0][MS_W-1:0] vals);
        logic [CFG_IDX_W-1:0] idx;
        for (int k = 0; k < 8; k++) begin
            idx = k[CFG_IDX_W-1:0];
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data <= vals[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            if (idx == REG_INIT_DOOR) begin
                sq_reg[idx] = {{(MS_W-DOOR_W){1'b0}}, vals[k][DOOR_W-1:0]};
                sq_door = vals[k][DOOR_W-1:0];
            end else if (idx < REG_INIT_DOOR) begin
                sq_reg[idx] = vals[k];
            end
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly follows the sequence the controller waits for, with some noise.
    task automatic choose_command(output logic [CMD_W-1:0] cmd, output logic lk,
                                  output logic op);
        int roll;
        logic [DOOR_W-1:0] want;
        logic [DOOR_W-1:0] awaited;
        roll = $urandom_range(99);
        want = DOOR_W'($urandom_range(3));
        cmd = CMD_SENSOR;
        if (roll < 15) begin
            cmd = CMD_W'($urandom_range(7));
        end else if (sq_state == CS_IDLE) begin
            if (roll < 70)
                cmd = CMD_W'($urandom_range(CMD_CLOSE));
            else if (roll < 75)
                cmd = CMD_TIMEOUT;
        end else if (sq_state == CS_INIT_OPEN || sq_state == CS_INIT_LOCK) begin
            if (roll < 85)
                cmd = CMD_TIMEOUT;
        end else begin
            case (sq_state)
                CS_WAIT_OPEN:   awaited = DS_OPEN;
                CS_WAIT_LOCKED: awaited = DS_LOCKED;
                default:        awaited = DS_CLOSED;
            endcase
            if (roll < 65)
                want = awaited;
            else if (roll < 85)
                cmd = CMD_TIMEOUT;
        end
        {op, lk} = want;
    endtask

    // Receiver back-pressure: picks a new mode at random from none, light, heavy and a rotating pattern.
    t_stall_mode stall_mode = STALL_NONE;
    logic [7:0]  stall_pat = '0;
    int          stall_left = 0;

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(3));
            stall_left <= $urandom_range(160, 16);
            stall_pat <= 8'($urandom);
            i_out_stall <= 1'b0;
        end else begin
            stall_left <= stall_left - 1;
            stall_pat <= {stall_pat[6:0], stall_pat[7]};
            case (stall_mode)
                STALL_NONE:  i_out_stall <= 1'b0;
                STALL_LIGHT: i_out_stall <= ($urandom_range(99) < 25);
                STALL_HEAVY: i_out_stall <= ($urandom_range(99) < 75);
                default:     i_out_stall <= stall_pat[7];
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_door_result got;
        t_door_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = mk_res(o_error_code, o_signal_code, o_trigger_open, o_trigger_close,
                         o_timer_load, o_timeout_ms, o_controller_state, o_door_now);
            if (pending_results.size() == 0) begin
                fails++;
                if (fails <= MAX_REPORTS)
                    $display("unexpected result item at %0t", $realtime);
            end else begin
                want = pending_results.pop_front();
                if (got.err !== want.err || got.sig !== want.sig
                        || got.trig_open !== want.trig_open
                        || got.trig_close !== want.trig_close
                        || got.load !== want.load || got.ms !== want.ms
                        || got.state !== want.state || got.door !== want.door) begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display({"mismatch at %0t: expected err=%0d sig=%0d open=%0b ",
                                  "close=%0b load=%0b ms=%0d state=%0d door=%0d, got err=%0d ",
                                  "sig=%0d open=%0b close=%0b load=%0b ms=%0d state=%0d door=%0d"},
                                 $realtime, want.err, want.sig, want.trig_open,
                                 want.trig_close, want.load, want.ms, want.state, want.door,
                                 got.err, got.sig, got.trig_open, got.trig_close, got.load,
                                 got.ms, got.state, got.door);
                end
            end
        end
    end

    int unsigned cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    t_stim_row plan [$];

    task automatic add_row(input logic [CMD_W-1:0] cmd, input logic lk, input logic op,
                           input logic typed, input t_door_result res);
        t_stim_row row;
        row.cmd = cmd;
        row.lk = lk;
        row.op = op;
        row.typed = typed;
        row.res = res;
        plan.push_back(row);
    endtask

    initial begin
        logic [7:0][MS_W-1:0] vals;
        logic [CMD_W-1:0] cmd;
        logic lk;
        logic op;
        int left;
        int burst;
        int roll;

        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_command <= CMD_OPEN_SAFE;
        i_lock_sensed <= 1'b0;
        i_open_sensed <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_BUTTON_PRESS;
        i_cfg_data <= '0;

        sq_state = CS_IDLE;
        sq_door = RST_INIT_DOOR;
        sq_unsafe = 1'b0;
        sq_open_btn = 1'b0;
        sq_close_btn = 1'b0;
        sq_reg[REG_BUTTON_PRESS] = RST_BUTTON_PRESS;
        sq_reg[REG_ENGAGE_BOLT] = RST_ENGAGE_BOLT;
        sq_reg[REG_DISENGAGE] = RST_DISENGAGE;
        sq_reg[REG_USER_OPEN] = RST_USER_OPEN;
        sq_reg[REG_USER_CLOSE] = RST_USER_CLOSE;
        sq_reg[REG_INIT_DOOR] = {{(MS_W-DOOR_W){1'b0}}, RST_INIT_DOOR};

        // Directed walk through the full open and lock sequences and the corner cases.
        add_row(CMD_CLOSE, 1'b0, 1'b0, 1'b1,
                mk_res(ERR_OK, SG_NONE, 1'b0, 1'b0, 1'b0, '0, CS_IDLE, DS_LOCKED));
        add_row(CMD_OPEN_SAFE, 1'b0, 1'b0, 1'b1,
                mk_res(ERR_OK, SG_OPENING, 1'b1, 1'b0, 1'b1, RST_BUTTON_PRESS,
                       CS_INIT_OPEN, DS_LOCKED));
        add_row(CMD_OPEN_UNSAFE, 1'b0, 1'b0, 1'b1,
                mk_res(ERR_BUSY, SG_NONE, 1'b1, 1'b0, 1'b0, '0, CS_INIT_OPEN, DS_LOCKED));
        add_row(CMD_TIMEOUT, 1'b0, 1'b0, 1'b0, '0);
        add_row(CMD_SENSOR, 1'b0, 1'b0, 1'b0, '0);
        add_row(CMD_SENSOR, 1'b1, 1'b1, 1'b0, '0);
        add_row(CMD_SENSOR, 1'b0, 1'b1, 1'b0, '0);
        add_row(CMD_CLOSE, 1'b0, 1'b0, 1'b0, '0);
        add_row(CMD_TIMEOUT, 1'b0, 1'b0, 1'b0, '0);
        add_row(CMD_CLOSE, 1'b0, 1'b0, 1'b0, '0);
        add_row(CMD_SENSOR, 1'b0, 1'b0, 1'b0, '0);
        add_row(CMD_TIMEOUT, 1'b0, 1'b0, 1'b0, '0);
        add_row(CMD_SENSOR, 1'b1, 1'b0, 1'b0, '0);
        add_row(CMD_OPEN_UNSAFE, 1'b0, 1'b0, 1'b0, '0);
        add_row(CMD_SENSOR, 1'b0, 1'b0, 1'b0, '0);
        add_row(CMD_TIMEOUT, 1'b0, 1'b0, 1'b0, '0);
        add_row(CMD_SENSOR, 1'b1, 1'b0, 1'b0, '0);
        add_row(CMD_SENSOR, 1'b0, 1'b0, 1'b0, '0);
        add_row(CMD_OPEN_SAFE, 1'b0, 1'b0, 1'b0, '0);
        add_row(CMD_TIMEOUT, 1'b0, 1'b0, 1'b0, '0);
        add_row(CMD_SENSOR, 1'b0, 1'b0, 1'b0, '0);
        add_row(CMD_SENSOR, 1'b1, 1'b1, 1'b0, '0);
        add_row(CMD_OPEN_SAFE, 1'b0, 1'b0, 1'b1,
                mk_res(ERR_FAULT, SG_NONE, 1'b0, 1'b0, 1'b0, '0, CS_IDLE, DS_FAULT));
        add_row(CMD_CLOSE, 1'b0, 1'b0, 1'b1,
                mk_res(ERR_FAULT, SG_NONE, 1'b0, 1'b0, 1'b0, '0, CS_IDLE, DS_FAULT));
        add_row(CMD_RSVD_A, 1'b1, 1'b1, 1'b1,
                mk_res(ERR_OK, SG_NONE, 1'b0, 1'b0, 1'b0, '0, CS_IDLE, DS_FAULT));
        add_row(CMD_RSVD_B, 1'b1, 1'b0, 1'b0, '0);
        add_row(CMD_RSVD_C, 1'b0, 1'b1, 1'b0, '0);
        add_row(CMD_SENSOR, 1'b1, 1'b0, 1'b0, '0);
        add_row(CMD_SENSOR, 1'b0, 1'b0, 1'b0, '0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[n])
            offer(plan[n].cmd, plan[n].lk, plan[n].op, plan[n].typed, plan[n].res);
        i_in_valid <= 1'b0;
        await_results();

        for (int ph = 0; ph < PHASES; ph++) begin
            for (int k = 0; k < 8; k++) begin
                case (ph)
                    0:       vals[k] = '0;
                    1:       vals[k] = '1;
                    default: vals[k] = MS_W'($urandom);
                endcase
            end
            vals[6] = MS_W'($urandom);
            vals[7] = MS_W'($urandom);
            program_registers(vals);

            left = PHASE_ITEMS;
            while (left > 0) begin
                burst = $urandom_range(24, 1);
                for (int b = 0; b < burst && left > 0; b++) begin
                    choose_command(cmd, lk, op);
                    offer(cmd, lk, op, 1'b0, '0);
                    left--;
                end
                roll = $urandom_range(99);
                if (left == 0 || roll >= 30) begin
                    i_in_valid <= 1'b0;
                    if (left > 0) begin
                        // Now and then let the block run completely dry.
                        if (roll < 34)
                            await_results();
                        else
                            repeat ($urandom_range(8, 1)) @(posedge i_clk);
                    end
                end
            end
            await_results();
        end

        if (fails == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
